[sv/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Types and codes shared by the priority task scheduler and its tests.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_DELAY = 2'd2;
    localparam logic [1:0] CMD_SCHED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  task_id;
        logic [31:0] delay_ticks;
        logic [1:0]  priority_req;
        logic        start_paused;
    } pts_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       granted;
        logic [4:0] result_task;
    } pts_out_t;

    typedef struct packed {
        logic [1:0]  level;
        logic        paused;
        logic [31:0] wake;
    } pts_entry_t;

endpackage

[sv/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority cooperative scheduler with a task table held in one RAM.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ channel as one transaction each, and every
// command returns exactly one result transaction on the m_ channel.
// The block works on one command at a time. A tick or an add goes from
// acceptance straight to the finish state, while a delay passes through a
// further state first, since it reads the task entry and writes it back.
// A schedule command sweeps the task table through the RAM, one entry per
// cycle, waking and checking each task in ring order from the search
// position; with an empty table it goes straight to the finish state.
// The result sits in an output register, so a new command is accepted while
// the previous result still waits; a stalled receiver holds the block only
// when the next result is ready to be delivered.
// Reset clears the task count, search position, tick counter and the output
// valid. Table entries are written by add before they are ever read.
// ----------------------------------------------------------------------------
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pts_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pts_out_t m_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int ENT_W = $bits(pts_entry_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELAY = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [31:0]      tick_reg, tick_next;
    pts_in_t          req_reg, req_next;
    pts_out_t         res_reg, res_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             found_reg, found_next;
    logic [1:0]       best_lvl_reg, best_lvl_next;
    logic [IDX_W-1:0] best_slot_reg, best_slot_next;
    logic             m_valid_reg, m_valid_next;
    pts_out_t         m_data_reg, m_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    pts_entry_t       ram_wdata, ram_rdata;

    logic             accept;
    logic [CW-1:0]    tid_ext, cnt_ext;
    logic [IDX_W-1:0] tid_slot, ring_next;
    logic             woke_paused, take;
    logic [IDX_W-1:0] sel_slot;

    pts_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TASKS)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign tid_ext   = CW'(s_data.task_id);
    assign cnt_ext   = CW'(count_reg);
    assign tid_slot  = IDX_W'(tid_ext - CW'(1));
    assign ring_next = (CNT_W'(slot_reg) == count_reg - CNT_W'(1)) ? '0 : slot_reg + IDX_W'(1);

    assign woke_paused = ram_rdata.paused && !(ram_rdata.wake <= tick_reg);
    assign take        = !woke_paused && (!found_reg || (ram_rdata.level < best_lvl_reg));
    assign sel_slot    = take ? slot_reg : best_slot_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        tick_next      = tick_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        slot_next      = slot_reg;
        left_next      = left_reg;
        found_next     = found_reg;
        best_lvl_next  = best_lvl_reg;
        best_slot_next = best_slot_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = pos_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next  = s_data;
                    res_next  = '0;
                    state_next = S_FIN;
                    unique case (s_data.cmd)
                        CMD_TICK: begin
                            tick_next = tick_reg + 32'd1;
                        end
                        CMD_ADD: begin
                            if (count_reg == CNT_W'(MAX_TASKS)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                ram_we           = 1'b1;
                                ram_waddr        = IDX_W'(count_reg);
                                ram_wdata.level  = s_data.priority_req;
                                ram_wdata.paused = s_data.start_paused;
                                ram_wdata.wake   = '0;
                                count_next       = count_reg + CNT_W'(1);
                                pos_next         = IDX_W'(count_reg);
                                res_next.result_task = 5'(cnt_ext + CW'(1));
                            end
                        end
                        CMD_DELAY: begin
                            if (tid_ext == '0 || tid_ext > cnt_ext) begin
                                res_next.status = ST_UNKNOWN;
                            end else begin
                                ram_raddr  = tid_slot;
                                slot_next  = tid_slot;
                                state_next = S_DELAY;
                            end
                        end
                        CMD_SCHED: begin
                            if (count_reg != '0) begin
                                ram_raddr  = pos_reg;
                                slot_next  = pos_reg;
                                left_next  = count_reg - CNT_W'(1);
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DELAY: begin
                ram_we           = 1'b1;
                ram_waddr        = slot_reg;
                ram_wdata.level  = ram_rdata.level;
                ram_wdata.paused = 1'b1;
                ram_wdata.wake   = tick_reg + req_reg.delay_ticks;
                pos_next         = slot_reg;
                state_next       = S_FIN;
            end
            S_SCAN: begin
                ram_we           = 1'b1;
                ram_waddr        = slot_reg;
                ram_wdata.paused = woke_paused;
                if (take) begin
                    found_next     = 1'b1;
                    best_lvl_next  = ram_rdata.level;
                    best_slot_next = slot_reg;
                end
                if (left_reg != '0) begin
                    ram_raddr = ring_next;
                    slot_next = ring_next;
                    left_next = left_reg - CNT_W'(1);
                end else begin
                    if (found_reg || take) begin
                        pos_next             = sel_slot;
                        res_next.granted     = 1'b1;
                        res_next.result_task = 5'(CW'(sel_slot) + CW'(1));
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        slot_reg      <= slot_next;
        left_reg      <= left_next;
        found_reg     <= found_next;
        best_lvl_reg  <= best_lvl_next;
        best_slot_reg <= best_slot_next;
        m_data_reg    <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count exceeds table depth");

    a_pos_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> CNT_W'(pos_reg) < count_reg)
        else $error("search position outside populated table");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("command accepted while another is in progress");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.granted |-> m_data.status == ST_OK)
        else $error("grant reported with error status");

    a_scan_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> ram_we && ram_waddr != ram_raddr || left_reg == '0)
        else $error("scan read collides with write-back");
`endif

endmodule

[verif/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker
// Watches both channels of the priority task scheduler, predicts every
// result transaction from the accepted commands and compares it field by
// field. The number of failures and of results still owed go to the top.
// ----------------------------------------------------------------------------
module pts_checker
    import pts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  pts_in_t     s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  pts_out_t    m_data,
    output int unsigned mismatches,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  level_tbl [SLOTS];
    logic        paused_tbl[SLOTS];
    logic [31:0] wake_tbl  [SLOTS];
    int unsigned n_tasks;
    int unsigned cursor;
    logic [31:0] now;

    pts_out_t owed_results[$];
    pts_out_t want;
    int unsigned fail_count = 0;

    assign mismatches = fail_count;

    function automatic pts_out_t run_command(input pts_in_t c);
        pts_out_t    r;
        int unsigned start;
        int unsigned slot;
        bit          found;
        r     = '0;
        found = 1'b0;
        case (c.cmd)
            CMD_TICK: begin
                now = now + 32'd1;
            end
            CMD_ADD: begin
                if (n_tasks >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    level_tbl[n_tasks]  = c.priority_req;
                    paused_tbl[n_tasks] = c.start_paused;
                    wake_tbl[n_tasks]   = 32'd0;
                    cursor              = n_tasks;
                    n_tasks             = n_tasks + 1;
                    r.result_task       = 5'(n_tasks);
                end
            end
            CMD_DELAY: begin
                if (c.task_id == 5'd0 || c.task_id > n_tasks) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    slot             = c.task_id - 1;
                    wake_tbl[slot]   = now + c.delay_ticks;
                    paused_tbl[slot] = 1'b1;
                    cursor           = slot;
                end
            end
            default: begin
                if (n_tasks != 0) begin
                    for (int i = 0; i < n_tasks; i++) begin
                        if (paused_tbl[i] && wake_tbl[i] <= now) begin
                            paused_tbl[i] = 1'b0;
                        end
                    end
                    start = cursor % n_tasks;
                    for (int lvl = 0; lvl < 4 && !found; lvl++) begin
                        for (int i = 0; i < n_tasks && !found; i++) begin
                            slot = (start + i) % n_tasks;
                            if (!paused_tbl[slot] && level_tbl[slot] == 2'(lvl)) begin
                                found         = 1'b1;
                                cursor        = slot;
                                r.granted     = 1'b1;
                                r.result_task = 5'(slot + 1);
                            end
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                level_tbl[i]  = '0;
                paused_tbl[i] = 1'b0;
                wake_tbl[i]   = '0;
            end
            n_tasks = 0;
            cursor  = 0;
            now     = '0;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %p",
                             $time, m_data);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("granted", want.granted, m_data.granted);
                    check_field("result_task", want.result_task, m_data.result_task);
                end
            end
            if (s_valid && s_ready) begin
                owed_results.push_back(run_command(s_data));
            end
        end
        pending <= owed_results.size();
    end

endmodule

[verif/tb_priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler
// Drives directed and random commands into the priority task scheduler with
// random gaps on the command side and random stalls on the result side, and
// reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler
    import pts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT  = 250000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pts_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pts_out_t m_data;

    int unsigned mismatches;
    int unsigned pending;
    bit          steady = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    priority_task_scheduler #(
        .MAX_TASKS(SLOTS)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    pts_checker #(
        .SLOTS(SLOTS)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 24);
    end

    function automatic pts_in_t cmd_item(input logic [1:0] op, input logic [4:0] id,
                                         input logic [31:0] dly, input logic [1:0] prio,
                                         input logic sp);
        pts_in_t c;
        c.cmd          = op;
        c.task_id      = id;
        c.delay_ticks  = dly;
        c.priority_req = prio;
        c.start_paused = sp;
        return c;
    endfunction

    function automatic pts_in_t random_command();
        pts_in_t     c;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            c.cmd = CMD_TICK;
        end else if (roll < 42) begin
            c.cmd = CMD_ADD;
        end else if (roll < 70) begin
            c.cmd = CMD_DELAY;
        end else begin
            c.cmd = CMD_SCHED;
        end
        if ($urandom_range(99) < 75) begin
            c.task_id = 5'($urandom_range(SLOTS, 1));
        end else begin
            c.task_id = 5'($urandom_range(31, 0));
        end
        roll = $urandom_range(99);
        if (roll < 60) begin
            c.delay_ticks = $urandom_range(12, 0);
        end else if (roll < 85) begin
            c.delay_ticks = $urandom;
        end else begin
            case ($urandom_range(3))
                0: c.delay_ticks = 32'h0000_0000;
                1: c.delay_ticks = 32'hFFFF_FFFF;
                2: c.delay_ticks = 32'h8000_0000;
                default: c.delay_ticks = 32'h7FFF_FFFF;
            endcase
        end
        c.priority_req = 2'($urandom_range(3));
        c.start_paused = 1'($urandom_range(1));
        return c;
    endfunction

    task automatic send_cmd(input pts_in_t item);
        logic rdy;
        while (!steady && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd0, 32'd5, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd1, 32'd5, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_TICK, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_ADD, 5'd0, 32'd0, 2'd3, 1'b0));
        send_cmd(cmd_item(CMD_ADD, 5'd0, 32'd0, 2'd2, 1'b1));
        send_cmd(cmd_item(CMD_ADD, 5'd0, 32'd0, 2'd1, 1'b0));
        send_cmd(cmd_item(CMD_ADD, 5'd0, 32'd0, 2'd0, 1'b1));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd4, 32'hFFFF_FFFF, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd4, 32'h8000_0000, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd3, 32'd2, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_TICK, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_TICK, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd5, 32'd1, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_DELAY, 5'd31, 32'hFFFF_FFFF, 2'd3, 1'b1));
        send_cmd(cmd_item(CMD_ADD, 5'd0, 32'd0, 2'd1, 1'b0));
        send_cmd(cmd_item(CMD_SCHED, 5'd0, 32'd0, 2'd0, 1'b0));
        send_cmd(cmd_item(CMD_ADD, 5'd31, 32'hFFFF_FFFF, 2'd3, 1'b1));
        send_cmd(cmd_item(CMD_SCHED, 5'd31, 32'hFFFF_FFFF, 2'd3, 1'b1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 350 && n < 550);
            send_cmd(random_command());
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        @(negedge aclk);
        wait (pending == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
